### src/assert_macros.svh
// Assertion macros shared by the heading unwrap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HUS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hus assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HUS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hus assertion failed");

`endif

### src/hus_pkg.sv
// Types and constants of the heading unwrap and spike reject block.
`timescale 1ns / 1ps
`default_nettype none

package hus_pkg;

  localparam int RAW_W      = 16;
  localparam int TICK_W     = 32;
  localparam int HEAD_W     = 32;
  localparam int RATE_W     = 22;
  localparam int GAP_W      = 8;
  localparam int LIM_W      = 15;
  localparam int TPS_W      = 10;
  localparam int DIFF_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PROD_W     = RAW_W + TPS_W;
  localparam int DIV_DIGIT  = 2;
  localparam int DIV_STEPS  = PROD_W / DIV_DIGIT;
  localparam int DIV_CNT_W  = 4;
  localparam int WRAP_HALF  = 18000;
  localparam int WRAP_FULL  = 36000;

  localparam logic [HEAD_W-1:0] HEAD_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
  localparam logic [HEAD_W-1:0] HEAD_MIN = {1'b1, {(HEAD_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] RATE_POS_LIM = PROD_W'((1 << (RATE_W - 1)) - 1);
  localparam logic [PROD_W-1:0] RATE_NEG_LIM = PROD_W'(1 << (RATE_W - 1));
  localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  localparam logic [LIM_W-1:0]  RST_SPIKE_LIMIT = LIM_W'(5000);
  localparam logic [LIM_W-1:0]  RST_SPIKE_CAP   = LIM_W'(18000);
  localparam logic [GAP_W-1:0]  RST_MAX_GAP     = GAP_W'(10);
  localparam logic [TPS_W-1:0]  RST_TPS         = TPS_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIKE_LIMIT_PER_TICK = 2'd0,
    CFG_SPIKE_LIMIT_CAP      = 2'd1,
    CFG_MAX_GAP_TICKS        = 2'd2,
    CFG_TICKS_PER_SECOND     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LIM_W-1:0] spike_limit_per_tick;
    logic [LIM_W-1:0] spike_limit_cap;
    logic [GAP_W-1:0] max_gap_ticks;
    logic [TPS_W-1:0] ticks_per_second;
  } hus_cfg_t;

  typedef struct packed {
    logic signed [RAW_W-1:0]  used;
    logic                     rate_zero;
    logic [GAP_W-1:0]         gap;
    logic                     rej;
    logic signed [HEAD_W-1:0] heading;
    logic signed [RAW_W-1:0]  offset;
  } hus_res_t;

endpackage

`default_nettype wire

### src/hus_if.sv
// Valid/ready channel interfaces for heading samples and results.
`timescale 1ns / 1ps
`default_nettype none

interface hus_in_if;
  import hus_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [RAW_W-1:0] raw_heading;
  logic [TICK_W-1:0]       tick_count;

  modport source (output valid, output op, output raw_heading, output tick_count,
                  input ready);
  modport sink (input valid, input op, input raw_heading, input tick_count,
                output ready);
endinterface

interface hus_out_if;
  import hus_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] heading;
  logic signed [RAW_W-1:0]  heading_offset;
  logic signed [RATE_W-1:0] heading_rate;
  logic [GAP_W-1:0]         gap_ticks;
  logic                     spike_rejected;

  modport source (output valid, output heading, output heading_offset,
                  output heading_rate, output gap_ticks, output spike_rejected,
                  input ready);
  modport sink (input valid, input heading, input heading_offset,
                input heading_rate, input gap_ticks, input spike_rejected,
                output ready);
endinterface

`default_nettype wire

### src/hus_front.sv
// Gap, wrap and spike decision stages with the unwrap state registers.
`timescale 1ns / 1ps
`default_nettype none

module hus_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            op_i,
  input  wire logic signed [hus_pkg::RAW_W-1:0]  raw_i,
  input  wire logic [hus_pkg::TICK_W-1:0]      tick_i,
  input  wire hus_pkg::hus_cfg_t               cfg_i,
  output logic                                 done_o,
  output hus_pkg::hus_res_t                    res_o
);
  import hus_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_GAP, F_DEC, F_DONE} front_state_e;

  localparam logic signed [DIFF_W-1:0] WRAP_HALF_P = DIFF_W'(WRAP_HALF);
  localparam logic signed [DIFF_W-1:0] WRAP_HALF_N = DIFF_W'(-WRAP_HALF);
  localparam logic signed [DIFF_W-1:0] WRAP_FULL_D = DIFF_W'(WRAP_FULL);

  front_state_e             state_q;
  logic                     first_pending_q;
  logic                     tick_valid_q;
  logic [TICK_W-1:0]        last_tick_q;
  logic signed [RAW_W-1:0]  prev_raw_q;
  logic signed [RAW_W-1:0]  last_good_q;
  logic signed [HEAD_W-1:0] accum_q;
  logic signed [RAW_W-1:0]  offset_q;

  logic                     op_q;
  logic signed [RAW_W-1:0]  raw_q;
  logic [TICK_W-1:0]        tick_q;
  logic [GAP_W-1:0]         gap_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [RAW_W-1:0]  used_q;
  logic                     rate_zero_q;
  logic [GAP_W-1:0]         res_gap_q;
  logic                     rej_q;

  logic [TICK_W-1:0]          gap_diff;
  logic                       gap_ok;
  logic [GAP_W-1:0]           gap_d;
  logic signed [DIFF_W-1:0]   delta;
  logic signed [DIFF_W-1:0]   diff_d;
  logic [LIM_W+GAP_W-1:0]     limit_full;
  logic [LIM_W-1:0]           limit;
  logic [DIFF_W-1:0]          mag;
  logic                       rej;
  logic signed [RAW_W-1:0]    used;
  logic [HEAD_W:0]            sum;
  logic [HEAD_W-1:0]          sum_sat;
  logic signed [RAW_W-1:0]    used_d;
  logic                       rate_zero_d;
  logic [GAP_W-1:0]           res_gap_d;
  logic                       rej_d;

  always_comb begin
    gap_diff = tick_q - last_tick_q;
    gap_ok   = tick_valid_q && (gap_diff != '0) &&
               (gap_diff <= {{(TICK_W-GAP_W){1'b0}}, cfg_i.max_gap_ticks});
    gap_d    = gap_ok ? gap_diff[GAP_W-1:0] : GAP_W'(1);
    delta    = {raw_q[RAW_W-1], raw_q} - {prev_raw_q[RAW_W-1], prev_raw_q};
    if (delta > WRAP_HALF_P) begin
      diff_d = delta - WRAP_FULL_D;
    end else if (delta < WRAP_HALF_N) begin
      diff_d = delta + WRAP_FULL_D;
    end else begin
      diff_d = delta;
    end
  end

  always_comb begin
    limit_full = cfg_i.spike_limit_per_tick * gap_q;
    limit      = (limit_full > {{GAP_W{1'b0}}, cfg_i.spike_limit_cap}) ?
                 cfg_i.spike_limit_cap : limit_full[LIM_W-1:0];
    mag        = diff_q[DIFF_W-1] ? (~diff_q + 1'b1) : diff_q;
    rej        = mag > {{(DIFF_W-LIM_W){1'b0}}, limit};
    used       = rej ? last_good_q : diff_q[RAW_W-1:0];
    sum        = {accum_q[HEAD_W-1], accum_q} +
                 {{(HEAD_W+1-RAW_W){used[RAW_W-1]}}, used};
    if (sum[HEAD_W] != sum[HEAD_W-1]) begin
      sum_sat = sum[HEAD_W] ? HEAD_MIN : HEAD_MAX;
    end else begin
      sum_sat = sum[HEAD_W-1:0];
    end
    if (op_q) begin
      used_d      = '0;
      rate_zero_d = 1'b1;
      res_gap_d   = GAP_W'(1);
      rej_d       = 1'b0;
    end else if (first_pending_q) begin
      used_d      = '0;
      rate_zero_d = 1'b1;
      res_gap_d   = gap_q;
      rej_d       = 1'b0;
    end else begin
      used_d      = used;
      rate_zero_d = 1'b0;
      res_gap_d   = gap_q;
      rej_d       = rej;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= F_IDLE;
      first_pending_q <= 1'b1;
      tick_valid_q    <= 1'b0;
      last_tick_q     <= '0;
      prev_raw_q      <= '0;
      last_good_q     <= '0;
      accum_q         <= '0;
      offset_q        <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= F_GAP;
          end
        end
        F_GAP: begin
          if (!op_q) begin
            last_tick_q  <= tick_q;
            tick_valid_q <= 1'b1;
          end
          state_q <= F_DEC;
        end
        F_DEC: begin
          if (op_q) begin
            first_pending_q <= 1'b1;
            prev_raw_q      <= '0;
          end else if (first_pending_q) begin
            first_pending_q <= 1'b0;
            accum_q         <= {{(HEAD_W-RAW_W){raw_q[RAW_W-1]}}, raw_q};
            offset_q        <= raw_q;
            prev_raw_q      <= raw_q;
          end else begin
            if (!rej) begin
              last_good_q <= diff_q[RAW_W-1:0];
            end
            accum_q    <= sum_sat;
            prev_raw_q <= raw_q;
          end
          state_q <= F_DONE;
        end
        F_DONE: begin
          state_q <= F_IDLE;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      op_q   <= op_i;
      raw_q  <= raw_i;
      tick_q <= tick_i;
    end
    if (state_q == F_GAP) begin
      gap_q  <= gap_d;
      diff_q <= diff_d;
    end
    if (state_q == F_DEC) begin
      used_q      <= used_d;
      rate_zero_q <= rate_zero_d;
      res_gap_q   <= res_gap_d;
      rej_q       <= rej_d;
    end
  end

  assign done_o            = (state_q == F_DONE);
  assign res_o.used        = used_q;
  assign res_o.rate_zero   = rate_zero_q;
  assign res_o.gap         = res_gap_q;
  assign res_o.rej         = rej_q;
  assign res_o.heading     = accum_q;
  assign res_o.offset      = offset_q;

endmodule

`default_nettype wire

### src/hus_div.sv
// Rate unit: one product, then a shift-register divider retiring two quotient bits a cycle.
`timescale 1ns / 1ps
`default_nettype none

module hus_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [hus_pkg::RAW_W-1:0]  used_i,
  input  wire logic                              rate_zero_i,
  input  wire logic [hus_pkg::TPS_W-1:0]         tps_i,
  input  wire logic [hus_pkg::GAP_W-1:0]         gap_i,
  output logic                                   done_o,
  output logic                                   neg_o,
  output logic [hus_pkg::PROD_W-1:0]             quo_o
);
  import hus_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_STEP, D_DONE} div_state_e;

  div_state_e           state_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [RAW_W-1:0]  mag_q;
  logic              neg_q;
  logic [PROD_W-1:0] work_q;
  logic [GAP_W-1:0]  rem_q;

  logic [RAW_W-1:0]  mag_d;
  logic [GAP_W:0]    t1;
  logic [GAP_W:0]    t2;
  logic              ge1;
  logic              ge2;
  logic [GAP_W:0]    r1;
  logic [GAP_W:0]    r2;

  always_comb begin
    mag_d = used_i[RAW_W-1] ? (~used_i + 1'b1) : used_i;
    t1    = {rem_q, work_q[PROD_W-1]};
    ge1   = t1 >= {1'b0, gap_i};
    r1    = ge1 ? (t1 - {1'b0, gap_i}) : t1;
    t2    = {r1[GAP_W-1:0], work_q[PROD_W-2]};
    ge2   = t2 >= {1'b0, gap_i};
    r2    = ge2 ? (t2 - {1'b0, gap_i}) : t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_MUL;
          end
        end
        D_MUL: begin
          cnt_q   <= '0;
          state_q <= D_STEP;
        end
        D_STEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= D_DONE;
          end
        end
        D_DONE: begin
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      mag_q <= rate_zero_i ? '0 : mag_d;
      neg_q <= used_i[RAW_W-1] & ~rate_zero_i;
    end
    if (state_q == D_MUL) begin
      work_q <= mag_q * tps_i;
      rem_q  <= '0;
    end
    if (state_q == D_STEP) begin
      work_q <= {work_q[PROD_W-3:0], ge1, ge2};
      rem_q  <= r2[GAP_W-1:0];
    end
  end

  assign done_o = (state_q == D_DONE);
  assign neg_o  = neg_q;
  assign quo_o  = work_q;

endmodule

`default_nettype wire

### src/heading_unwrap_spike_reject_unit.sv
// Top level of the heading unwrap and spike reject block.
// Heading samples enter on in_i (valid/ready); op 0 is a sample, op 1 restarts
// unwrapping so that the next sample sets heading and offset. One result per
// item leaves on out_o (valid/ready) with the unwrapped heading, the offset,
// the rate in centidegrees per second, the gap used and the spike flag.
// An item is taken only while the core is idle, so a new item is taken only
// once the result of the last one has been loaded into the output register.
// The rate divider retires two quotient bits a cycle, after the gap, wrap and
// spike decision stages.
// The result sits in an output register, so the core returns to idle once the
// register is free; while the receiver stalls with a result still held, the
// next item is worked on and waits in the core until that register empties.
// Configuration writes through cfg_we_i take effect at once; the user must make
// them only while the block is idle, as the block itself does not enforce it.
// Reset loads the register defaults, clears heading, offset and tick history
// and arms the first-sample capture; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module heading_unwrap_spike_reject_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  hus_in_if.sink                                   in_i,
  hus_out_if.source                                out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [hus_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [hus_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import hus_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FRONT, ST_DIV, ST_OUT} top_state_e;

  top_state_e  state_q;
  hus_cfg_t    cfg_q;
  logic        out_valid_q;

  logic signed [HEAD_W-1:0] out_heading_q;
  logic signed [RAW_W-1:0]  out_offset_q;
  logic signed [RATE_W-1:0] out_rate_q;
  logic [GAP_W-1:0]         out_gap_q;
  logic                     out_rej_q;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_load;
  logic              front_done;
  hus_res_t          front_res;
  logic              div_done;
  logic              div_neg;
  logic [PROD_W-1:0] div_quo;
  logic [RATE_W-1:0] rate_d;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_valid_q && out_o.ready;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  hus_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .op_i    (in_i.op),
    .raw_i   (in_i.raw_heading),
    .tick_i  (in_i.tick_count),
    .cfg_i   (cfg_q),
    .done_o  (front_done),
    .res_o   (front_res)
  );

  hus_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (front_done),
    .used_i      (front_res.used),
    .rate_zero_i (front_res.rate_zero),
    .tps_i       (cfg_q.ticks_per_second),
    .gap_i       (front_res.gap),
    .done_o      (div_done),
    .neg_o       (div_neg),
    .quo_o       (div_quo)
  );

  always_comb begin
    if (div_neg) begin
      rate_d = (div_quo > RATE_NEG_LIM) ? RATE_MIN : (~div_quo[RATE_W-1:0] + 1'b1);
    end else begin
      rate_d = (div_quo > RATE_POS_LIM) ? RATE_MAX : div_quo[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_FRONT;
          end
        end
        ST_FRONT: begin
          if (front_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_limit_per_tick <= RST_SPIKE_LIMIT;
      cfg_q.spike_limit_cap      <= RST_SPIKE_CAP;
      cfg_q.max_gap_ticks        <= RST_MAX_GAP;
      cfg_q.ticks_per_second     <= RST_TPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPIKE_LIMIT_PER_TICK: cfg_q.spike_limit_per_tick <= cfg_data_i[LIM_W-1:0];
        CFG_SPIKE_LIMIT_CAP:      cfg_q.spike_limit_cap      <= cfg_data_i[LIM_W-1:0];
        CFG_MAX_GAP_TICKS:        cfg_q.max_gap_ticks        <= cfg_data_i[GAP_W-1:0];
        CFG_TICKS_PER_SECOND:     cfg_q.ticks_per_second     <= cfg_data_i[TPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_heading_q <= front_res.heading;
      out_offset_q  <= front_res.offset;
      out_rate_q    <= rate_d;
      out_gap_q     <= front_res.gap;
      out_rej_q     <= front_res.rej;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.heading        = out_heading_q;
  assign out_o.heading_offset = out_offset_q;
  assign out_o.heading_rate   = out_rate_q;
  assign out_o.gap_ticks      = out_gap_q;
  assign out_o.spike_rejected = out_rej_q;

  `HUS_ASSERT_NXT(a_accept_starts_front, clk_i, rst_ni, in_xfer, state_q == ST_FRONT)
  `HUS_ASSERT_IMP(a_front_done_in_front, clk_i, rst_ni, front_done, state_q == ST_FRONT)
  `HUS_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `HUS_ASSERT_NXT(a_load_sets_valid, clk_i, rst_ni, out_load, out_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire
